// File: rtl/config_text_lexer_unit_defines.svh
// assertion macros for the config text lexer unit
// used by ctl_lexer_core and ctl_token_fifo; no other dependencies
`ifndef CONFIG_TEXT_LEXER_UNIT_DEFINES_SVH
`define CONFIG_TEXT_LEXER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CTL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CTL_ASSERT(label, prop, msg)
`define CTL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/ctl_pkg.sv
// shared types and constants of the config text lexer unit
// no dependencies
package ctl_pkg;

   localparam int POSITION_BITS = 32;
   localparam int OUT_BITS      = 32;
   localparam int FIFO_DEPTH    = 8;
   localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 8;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 160;
   localparam int RSP_USER_BITS  = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_WS = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_CM = 8'd1;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   typedef logic [POSITION_BITS-1:0] pos_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WS, ST_COMMENT, ST_SQUOTE, ST_DQUOTE, ST_IDENT, ST_NUMBER
   } lex_state_type;

   typedef enum logic [3:0] {
      TK_WS, TK_COMMENT, TK_SQUOTE, TK_DQUOTE, TK_BRACKET, TK_COLON,
      TK_COMMA, TK_IDENT, TK_NUMBER, TK_UNKNOWN, TK_END, TK_UNTERM
   } tok_kind_type;

   typedef struct packed {
      logic                last_of_run;
      logic [OUT_BITS-1:0] start_column;
      logic [OUT_BITS-1:0] start_line;
      logic [OUT_BITS-1:0] content_length;
      logic [OUT_BITS-1:0] token_width;
      logic [OUT_BITS-1:0] start_offset;
      tok_kind_type        token_type;
   } token_type;

   typedef struct packed {
      logic      valid0;
      token_type tok0;
      logic      valid1;
      token_type tok1;
   } tok_pair_type;

endpackage

// File: rtl/config_text_lexer_unit.sv
// Config text lexer unit: streaming tokenizer of a configuration source text.
// Channels: req_ takes one word per source byte (req_tuser 0) and one
//   end-of-source word (req_tuser 1); rsp_ gives one token per word with its
//   type on rsp_tuser, tlast marks the last token caused by an input word;
//   csr_ writes the keep flags (index 0 keep whitespace, index 1 keep
//   comments), always ready.
// Path: a token that a word ends reaches rsp_ through the input register,
//   then the lexer logic into the token queue.
// Throughput: one input word per cycle while the receiver keeps up; an input
//   word yields zero to two tokens, so a word that ends one token and opens a
//   single-byte one gives two tokens on rsp_. req_tready drops while the
//   eight-entry token queue has fewer than two free slots past the word in
//   flight.
// Reset: lexer returns to idle, position to offset 0, line 1, column 1,
//   both keep flags to 1 and the queue empties.
// Receiver stall: tokens wait in the queue with rsp_ held; input is taken
//   while two slots stay free past the word in flight, then req_tready falls.
// depends on ctl_pkg, ctl_lexer_core and ctl_token_fifo
module config_text_lexer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ctl_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // source_byte
   input  logic                                req_tuser,  // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // start_offset, token_width, content_length, start_line, start_column
   output logic [ctl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [ctl_pkg::RSP_USER_BITS-1:0]   rsp_tuser,  // token_type
   output logic                                rsp_tlast,  // last_of_run
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ctl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ctl_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import ctl_pkg::*;

   logic in_valid_ff, in_valid_in;
   logic in_mode_ff;
   logic [7:0] in_byte_ff;
   tok_pair_type pair;
   token_type out_tok;
   logic [CNT_BITS-1:0] count;
   logic [CNT_BITS:0] committed;

   assign committed   = (CNT_BITS+1)'(count) + (in_valid_ff ? (CNT_BITS+1)'(2) : '0);
   assign req_tready  = (committed <= (CNT_BITS+1)'(FIFO_DEPTH - 2));
   assign in_valid_in = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_mode_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
      end
   end

   ctl_lexer_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_mode   (in_mode_ff),
      .in_byte   (in_byte_ff),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pair      (pair)
   );

   ctl_token_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok),
      .count     (count)
   );

   assign rsp_tdata = {out_tok.start_column, out_tok.start_line,
                       out_tok.content_length, out_tok.token_width,
                       out_tok.start_offset};
   assign rsp_tuser = out_tok.token_type;
   assign rsp_tlast = out_tok.last_of_run;

endmodule

// File: rtl/ctl_lexer_core.sv
// lexer state machine, position counters and configuration registers
// depends on ctl_pkg and config_text_lexer_unit_defines.svh
`include "config_text_lexer_unit_defines.svh"
module ctl_lexer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic                                in_mode,
   input  logic [7:0]                          in_byte,
   input  logic                                csr_valid,
   input  logic [ctl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ctl_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output ctl_pkg::tok_pair_type               pair
);
   import ctl_pkg::*;

   lex_state_type st_ff, st_in;
   pos_type p_start_ff, p_start_in, p_width_ff, p_width_in;
   pos_type p_line_ff, p_line_in, p_col_ff, p_col_in;
   pos_type off_ff, off_in, line_ff, line_in, col_ff, col_in;
   logic keep_ws_ff, keep_cm_ff;

   logic is_ws_b, is_alpha_b, is_digit_b, is_word_b, is_nl_b;
   lex_state_type cls_state;
   tok_kind_type cls_kind;
   token_type fin_tok;
   logic fin_emit, do_finish, do_begin;
   pos_type winc;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? v : v + POSITION_BITS'(1);
   endfunction

   function automatic logic [OUT_BITS-1:0] to_out(input pos_type v);
      logic [63:0] w;
      w = 64'(v);
      return w[OUT_BITS-1:0];
   endfunction

   function automatic token_type make_tok(input tok_kind_type k, input pos_type s,
                                          input pos_type w, input pos_type c,
                                          input pos_type l, input pos_type cl);
      token_type t;
      t.token_type     = k;
      t.start_offset   = to_out(s);
      t.token_width    = to_out(w);
      t.content_length = to_out(c);
      t.start_line     = to_out(l);
      t.start_column   = to_out(cl);
      t.last_of_run    = 1'b0;
      return t;
   endfunction

   // byte classes
   always_comb begin
      is_nl_b    = (in_byte == 8'h0a);
      is_ws_b    = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0d) || is_nl_b;
      is_alpha_b = ((in_byte >= 8'h61) && (in_byte <= 8'h7a)) ||
                   ((in_byte >= 8'h41) && (in_byte <= 8'h5a));
      is_digit_b = (in_byte >= 8'h30) && (in_byte <= 8'h39);
      is_word_b  = is_alpha_b || is_digit_b || (in_byte == 8'h5f);
      cls_state  = ST_IDLE;
      cls_kind   = TK_UNKNOWN;
      if (is_ws_b) begin
         cls_state = ST_WS;
      end else if (in_byte == 8'h23) begin
         cls_state = ST_COMMENT;
      end else if (in_byte == 8'h27) begin
         cls_state = ST_SQUOTE;
      end else if (in_byte == 8'h22) begin
         cls_state = ST_DQUOTE;
      end else if (is_alpha_b || (in_byte == 8'h5f)) begin
         cls_state = ST_IDENT;
      end else if (is_digit_b) begin
         cls_state = ST_NUMBER;
      end else if ((in_byte == 8'h7b) || (in_byte == 8'h7d) ||
                   (in_byte == 8'h5b) || (in_byte == 8'h5d)) begin
         cls_kind = TK_BRACKET;
      end else if (in_byte == 8'h3a) begin
         cls_kind = TK_COLON;
      end else if (in_byte == 8'h2c) begin
         cls_kind = TK_COMMA;
      end
   end

   // pending token as it would be closed now
   always_comb begin
      fin_emit = 1'b0;
      fin_tok  = make_tok(TK_IDENT, p_start_ff, p_width_ff, p_width_ff, p_line_ff, p_col_ff);
      unique case (st_ff)
         ST_WS: begin
            fin_emit = keep_ws_ff;
            fin_tok.token_type = TK_WS;
         end
         ST_COMMENT: begin
            fin_emit = keep_cm_ff;
            fin_tok.token_type = TK_COMMENT;
            fin_tok.content_length = to_out(p_width_ff - POSITION_BITS'(1));
         end
         ST_IDENT: begin
            fin_emit = 1'b1;
         end
         ST_NUMBER: begin
            fin_emit = 1'b1;
            fin_tok.token_type = TK_NUMBER;
         end
         default: begin
            fin_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      st_in      = st_ff;
      p_start_in = p_start_ff;
      p_width_in = p_width_ff;
      p_line_in  = p_line_ff;
      p_col_in   = p_col_ff;
      off_in     = off_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      pair       = '0;
      do_finish  = 1'b0;
      do_begin   = 1'b0;
      winc       = sat_inc(p_width_ff);
      if (in_valid && !in_mode) begin
         unique case (st_ff)
            ST_IDLE: do_begin = 1'b1;
            ST_WS: begin
               if (is_ws_b) begin
                  p_width_in = winc;
               end else begin
                  do_finish = 1'b1;
                  do_begin  = 1'b1;
               end
            end
            ST_COMMENT: begin
               if (is_nl_b) begin
                  do_finish = 1'b1;
                  do_begin  = 1'b1;
               end else begin
                  p_width_in = winc;
               end
            end
            ST_IDENT, ST_NUMBER: begin
               if (is_word_b) begin
                  p_width_in = winc;
               end else begin
                  do_finish = 1'b1;
                  do_begin  = 1'b1;
               end
            end
            ST_SQUOTE, ST_DQUOTE: begin
               p_width_in = winc;
               if (((st_ff == ST_SQUOTE) && (in_byte == 8'h27)) ||
                   ((st_ff == ST_DQUOTE) && (in_byte == 8'h22))) begin
                  pair.valid0 = 1'b1;
                  pair.tok0 = make_tok((st_ff == ST_SQUOTE) ? TK_SQUOTE : TK_DQUOTE,
                                       p_start_ff, winc, winc - POSITION_BITS'(2),
                                       p_line_ff, p_col_ff);
                  st_in = ST_IDLE;
               end
            end
            default: do_begin = 1'b1;
         endcase
         if (do_finish) begin
            pair.valid0 = fin_emit;
            pair.tok0   = fin_tok;
            st_in       = ST_IDLE;
         end
         if (do_begin) begin
            if (cls_state == ST_IDLE) begin
               pair.valid1 = 1'b1;
               pair.tok1 = make_tok(cls_kind, off_ff, POSITION_BITS'(1), POSITION_BITS'(1),
                                    line_ff, col_ff);
               st_in = ST_IDLE;
            end else begin
               st_in      = cls_state;
               p_start_in = off_ff;
               p_width_in = POSITION_BITS'(1);
               p_line_in  = line_ff;
               p_col_in   = col_ff;
            end
         end
         off_in = sat_inc(off_ff);
         if (is_nl_b) begin
            line_in = sat_inc(line_ff);
            col_in  = POSITION_BITS'(1);
         end else begin
            col_in  = sat_inc(col_ff);
         end
      end else if (in_valid) begin
         if ((st_ff == ST_SQUOTE) || (st_ff == ST_DQUOTE)) begin
            pair.valid0 = 1'b1;
            pair.tok0 = make_tok(TK_UNTERM, p_start_ff, p_width_ff,
                                 p_width_ff - POSITION_BITS'(1), p_line_ff, p_col_ff);
         end else begin
            pair.valid0 = fin_emit;
            pair.tok0   = fin_tok;
         end
         pair.valid1 = 1'b1;
         pair.tok1 = make_tok(TK_END, off_ff, '0, '0, line_ff, col_ff);
         st_in      = ST_IDLE;
         p_start_in = '0;
         p_width_in = '0;
         p_line_in  = POSITION_BITS'(1);
         p_col_in   = POSITION_BITS'(1);
         off_in     = '0;
         line_in    = POSITION_BITS'(1);
         col_in     = POSITION_BITS'(1);
      end
      pair.tok0.last_of_run = !pair.valid1;
      pair.tok1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         off_ff     <= '0;
         line_ff    <= POSITION_BITS'(1);
         col_ff     <= POSITION_BITS'(1);
         keep_ws_ff <= 1'b1;
         keep_cm_ff <= 1'b1;
      end else begin
         st_ff   <= st_in;
         off_ff  <= off_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_KEEP_WS: keep_ws_ff <= csr_data[0];
               CSR_KEEP_CM: keep_cm_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_start_ff <= '0;
         p_width_ff <= '0;
         p_line_ff  <= POSITION_BITS'(1);
         p_col_ff   <= POSITION_BITS'(1);
      end else begin
         p_start_ff <= p_start_in;
         p_width_ff <= p_width_in;
         p_line_ff  <= p_line_in;
         p_col_ff   <= p_col_in;
      end
   end

   `CTL_ASSERT(a_end_resets_pos, in_valid && in_mode |=> (off_ff == '0) && (line_ff == POSITION_BITS'(1)) && (col_ff == POSITION_BITS'(1)) && (st_ff == ST_IDLE), "end item did not reset position")
   `CTL_ASSERT(a_end_emits_end, in_valid && in_mode |-> pair.valid1 && (pair.tok1.token_type == TK_END), "end item without end token")
   `CTL_ASSERT(a_byte_no_end, in_valid && !in_mode |-> !(pair.valid1 && (pair.tok1.token_type == TK_END)), "byte produced end token")
   `CTL_ASSERT(a_offset_steps, in_valid && !in_mode && (off_ff != POS_MAX) |=> off_ff == $past(off_ff) + POSITION_BITS'(1), "offset did not advance")

endmodule

// File: rtl/ctl_token_fifo.sv
// result queue taking up to two tokens a cycle and giving one a cycle while out_ready is high
// depends on ctl_pkg and config_text_lexer_unit_defines.svh
`include "config_text_lexer_unit_defines.svh"
module ctl_token_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_pkg::tok_pair_type         pair,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ctl_pkg::token_type            out_tok,
   output logic [ctl_pkg::CNT_BITS-1:0]  count
);
   import ctl_pkg::*;

   token_type mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in, wr1_ptr;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic pop;
   logic [CNT_BITS:0] pushes;

   always_comb begin
      pop      = out_valid && out_ready;
      pushes   = (CNT_BITS+1)'(pair.valid0) + (CNT_BITS+1)'(pair.valid1);
      wr1_ptr  = tail_ff + PTR_BITS'(pair.valid0);
      tail_in  = tail_ff + PTR_BITS'(pushes);
      head_in  = head_ff + PTR_BITS'(pop);
      count_in = CNT_BITS'((CNT_BITS+1)'(count_ff) + pushes - (CNT_BITS+1)'(pop));
   end

   assign out_valid = (count_ff != '0);
   assign out_tok   = mem_ff[head_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.valid0) begin
         mem_ff[tail_ff] <= pair.tok0;
      end
      if (pair.valid1) begin
         mem_ff[wr1_ptr] <= pair.tok1;
      end
   end

   `CTL_ASSERT(a_no_overflow, (CNT_BITS+1)'(count_ff) + pushes <= (CNT_BITS+1)'(FIFO_DEPTH) + (CNT_BITS+1)'(pop), "token queue overflow")
   `CTL_ASSERT(a_pop_drops, pop && (pushes == '0) |=> count_ff == $past(count_ff) - 1'b1, "pop did not reduce count")
   `CTL_ASSERT(a_pair_last, pair.valid0 && pair.valid1 |-> !pair.tok0.last_of_run && pair.tok1.last_of_run, "last flag on wrong token")

endmodule
